/* design/yuv2argb_pkg.sv */
`default_nettype none
package yuv2argb_pkg;

  localparam int unsigned SUM_W = 19;

  localparam logic signed [SUM_W-1:0] COEF_Y      = 19'sd298;
  localparam logic signed [SUM_W-1:0] COEF_RV     = 19'sd409;
  localparam logic signed [SUM_W-1:0] COEF_GU     = 19'sd100;
  localparam logic signed [SUM_W-1:0] COEF_GV     = 19'sd208;
  localparam logic signed [SUM_W-1:0] COEF_BU     = 19'sd516;
  localparam logic signed [SUM_W-1:0] LUMA_OFFSET = 19'sd16;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS  = 19'sd128;
  localparam logic        [8:0]       CHROMA_OFFSET = 9'd128;
  localparam logic        [7:0]       CHAN_MAX    = 8'd255;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic [7:0] alpha;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_first_argb;
    logic [31:0] pixel_second_argb;
  } out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // arithmetic shift by 8 then clamp to 0..255
  function automatic logic [7:0] clamp_shift(input logic signed [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[SUM_W-2:16]) begin
      res = CHAN_MAX;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

  // round(c * a / 255)
  function automatic logic [7:0] scale_by_alpha(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] t;
    logic [16:0] u;
    t = ({9'd0, c} * {9'd0, a}) + 17'd128;
    u = t + {8'd0, t[16:8]};
    return u[15:8];
  endfunction

endpackage
`default_nettype wire

/* design/yuv2argb_pixel.sv */
`default_nettype none
module yuv2argb_pixel (
  input  wire logic                                   [7:0] luma,
  input  wire logic signed                            [8:0] du,
  input  wire logic signed                            [8:0] dv,
  output      yuv2argb_pkg::rgb_t                           rgb
);

  logic signed [yuv2argb_pkg::SUM_W-1:0] c_s;
  logic signed [yuv2argb_pkg::SUM_W-1:0] du_s;
  logic signed [yuv2argb_pkg::SUM_W-1:0] dv_s;
  logic signed [yuv2argb_pkg::SUM_W-1:0] r_sum;
  logic signed [yuv2argb_pkg::SUM_W-1:0] g_sum;
  logic signed [yuv2argb_pkg::SUM_W-1:0] b_sum;

  assign du_s = yuv2argb_pkg::SUM_W'(du);
  assign dv_s = yuv2argb_pkg::SUM_W'(dv);
  assign c_s  = (yuv2argb_pkg::SUM_W'(signed'({1'b0, luma})) - yuv2argb_pkg::LUMA_OFFSET)
                * yuv2argb_pkg::COEF_Y;

  assign r_sum = c_s + yuv2argb_pkg::COEF_RV * dv_s + yuv2argb_pkg::ROUND_BIAS;
  assign g_sum = c_s - yuv2argb_pkg::COEF_GU * du_s - yuv2argb_pkg::COEF_GV * dv_s
                 + yuv2argb_pkg::ROUND_BIAS;
  assign b_sum = c_s + yuv2argb_pkg::COEF_BU * du_s + yuv2argb_pkg::ROUND_BIAS;

  always_comb begin
    rgb.r = yuv2argb_pkg::clamp_shift(r_sum);
    rgb.g = yuv2argb_pkg::clamp_shift(g_sum);
    rgb.b = yuv2argb_pkg::clamp_shift(b_sum);
  end

endmodule
`default_nettype wire

/* design/yuv_to_argb_pixel_pair_core.sv */
// BT.601 YUV to ARGB32 conversion for one pixel pair per item.
// Input channel: an item (two luma samples sharing one U/V pair plus an
// alpha byte) is taken at a rising edge with start high and busy low.
// busy is always low, so one item can be taken on every clock.
// Result channel: out_strobe is high for exactly one cycle with both ARGB
// words on out_data. The receiver cannot stall; results are never held.
// An item passes the input register, the color matrix and clamp
// register, and the alpha scaling and output register in that order.
// Throughput is one item per clock, set by the three-stage pipeline
// with no feedback.
// Configuration: cfg_data bit 0 selects premultiplied alpha; cfg_ready is
// always high and the write is taken when cfg_valid is high. Write only
// while no item is in flight.
// Reset (rst_n low, synchronous) clears the pipeline valid bits and the
// premultiply register; items in flight are dropped.
`default_nettype none
module yuv_to_argb_pixel_pair_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire yuv2argb_pkg::in_t   in_data,
  output      logic                out_strobe,
  output      yuv2argb_pkg::out_t  out_data,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic                cfg_data
);

  logic                 premult_r;
  logic                 v0_r;
  logic                 v1_r;
  logic                 v2_r;
  yuv2argb_pkg::in_t    in_r;
  yuv2argb_pkg::rgb_t   rgb0_r;
  yuv2argb_pkg::rgb_t   rgb1_r;
  logic [7:0]           alpha1_r;
  yuv2argb_pkg::out_t   out_r;
  yuv2argb_pkg::rgb_t   rgb0_nxt;
  yuv2argb_pkg::rgb_t   rgb1_nxt;
  yuv2argb_pkg::rgb_t   pm0;
  yuv2argb_pkg::rgb_t   pm1;
  yuv2argb_pkg::out_t   out_nxt;
  logic signed [8:0]    du;
  logic signed [8:0]    dv;
  logic                 accept;

  assign busy       = 1'b0;
  assign cfg_ready  = 1'b1;
  assign accept     = start && !busy;
  assign out_strobe = v2_r;
  assign out_data   = out_r;

  assign du = signed'({1'b0, in_r.chroma_u} - yuv2argb_pkg::CHROMA_OFFSET);
  assign dv = signed'({1'b0, in_r.chroma_v} - yuv2argb_pkg::CHROMA_OFFSET);

  yuv2argb_pixel u_pix0 (
    .luma (in_r.luma_first),
    .du   (du),
    .dv   (dv),
    .rgb  (rgb0_nxt)
  );

  yuv2argb_pixel u_pix1 (
    .luma (in_r.luma_second),
    .du   (du),
    .dv   (dv),
    .rgb  (rgb1_nxt)
  );

  always_comb begin
    pm0.r = yuv2argb_pkg::scale_by_alpha(rgb0_r.r, alpha1_r);
    pm0.g = yuv2argb_pkg::scale_by_alpha(rgb0_r.g, alpha1_r);
    pm0.b = yuv2argb_pkg::scale_by_alpha(rgb0_r.b, alpha1_r);
    pm1.r = yuv2argb_pkg::scale_by_alpha(rgb1_r.r, alpha1_r);
    pm1.g = yuv2argb_pkg::scale_by_alpha(rgb1_r.g, alpha1_r);
    pm1.b = yuv2argb_pkg::scale_by_alpha(rgb1_r.b, alpha1_r);
    if (premult_r) begin
      out_nxt.pixel_first_argb  = {alpha1_r, pm0.r, pm0.g, pm0.b};
      out_nxt.pixel_second_argb = {alpha1_r, pm1.r, pm1.g, pm1.b};
    end else begin
      out_nxt.pixel_first_argb  = {alpha1_r, rgb0_r.r, rgb0_r.g, rgb0_r.b};
      out_nxt.pixel_second_argb = {alpha1_r, rgb1_r.r, rgb1_r.g, rgb1_r.b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      premult_r <= 1'b0;
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        premult_r <= cfg_data;
      end
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (v0_r) begin
      rgb0_r   <= rgb0_nxt;
      rgb1_r   <= rgb1_nxt;
      alpha1_r <= in_r.alpha;
    end
    if (v1_r) begin
      out_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_strobe)
    else $error("item taken without a result three cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 3))
    else $error("result strobe without a matching item");

  a_alpha_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.pixel_first_argb[31:24] == out_data.pixel_second_argb[31:24])
    else $error("alpha bytes of the pair differ");

  a_premult_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && premult_r) |->
      (out_data.pixel_first_argb[23:16] <= out_data.pixel_first_argb[31:24]) &&
      (out_data.pixel_second_argb[7:0] <= out_data.pixel_second_argb[31:24]))
    else $error("premultiplied channel exceeds alpha");
`endif

endmodule
`default_nettype wire
